// ----- rtl/block_bump_allocator_core_macros.svh -----
// Assertion macros used by the checker file.
`ifndef BLOCK_BUMP_ALLOCATOR_CORE_MACROS_SVH
`define BLOCK_BUMP_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BBA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define BBA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bba_pkg.sv -----
// Types, codes and defaults shared by the bump allocator modules.
package bba_pkg;

  localparam int MAX_BLOCKS_DEF  = 16;
  localparam int MAX_ENTRIES_DEF = 256;
  localparam logic [31:0] BLOCK_SIZE_RST = 32'd4194304;

  localparam logic OP_ALLOC  = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SLOT   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] request_size;
    logic [31:0] vertex_id;
    logic [3:0]  target_block;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  block_index;
    logic [47:0] offset;
    logic [47:0] free_space;
  } out_item_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SLOT,
    CMD_BADDR,
    CMD_BEVAL,
    CMD_DECIDE,
    CMD_DIV,
    CMD_PADDR,
    CMD_PEVAL,
    CMD_RADDR,
    CMD_REVAL,
    CMD_TADDR,
    CMD_TEVAL,
    CMD_FULL,
    CMD_NOSLOT,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic is_remove;
    logic slot_hit;
    logic ent_last;
    logic blk_last;
    logic match;
    logic dec_fail;
    logic need_div;
    logic div_last;
  } stat_t;

endpackage

// ----- rtl/bba_ctrl.sv -----
// Sequencer for the bump allocator: walks the scans and owns the handshakes.
module bba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  bba_pkg::stat_t stat,
  output bba_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_SLOT, S_BADDR, S_BEVAL, S_DECIDE, S_DIV, S_PADDR,
    S_PEVAL, S_RADDR, S_REVAL, S_TADDR, S_TEVAL, S_FULL, S_NOSLOT, S_DONE
  } state_t;

  state_t state;
  logic   emit;

  assign in_ready = (state == S_IDLE);
  assign emit     = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    case (state)
      S_IDLE:   cmd = in_valid ? bba_pkg::CMD_LOAD : bba_pkg::CMD_NONE;
      S_SLOT:   cmd = bba_pkg::CMD_SLOT;
      S_BADDR:  cmd = bba_pkg::CMD_BADDR;
      S_BEVAL:  cmd = bba_pkg::CMD_BEVAL;
      S_DECIDE: cmd = bba_pkg::CMD_DECIDE;
      S_DIV:    cmd = bba_pkg::CMD_DIV;
      S_PADDR:  cmd = bba_pkg::CMD_PADDR;
      S_PEVAL:  cmd = bba_pkg::CMD_PEVAL;
      S_RADDR:  cmd = bba_pkg::CMD_RADDR;
      S_REVAL:  cmd = bba_pkg::CMD_REVAL;
      S_TADDR:  cmd = bba_pkg::CMD_TADDR;
      S_TEVAL:  cmd = bba_pkg::CMD_TEVAL;
      S_FULL:   cmd = bba_pkg::CMD_FULL;
      S_NOSLOT: cmd = bba_pkg::CMD_NOSLOT;
      S_DONE:   cmd = emit ? bba_pkg::CMD_EMIT : bba_pkg::CMD_NONE;
      default:  cmd = bba_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE:   if (in_valid) state <= S_START;
        S_START:  state <= stat.is_remove ? S_RADDR : S_SLOT;
        S_SLOT: begin
          if (stat.slot_hit) state <= S_BADDR;
          else if (stat.ent_last) state <= S_FULL;
        end
        S_BADDR:  state <= S_BEVAL;
        S_BEVAL:  state <= stat.blk_last ? S_DECIDE : S_BADDR;
        S_DECIDE: begin
          if (stat.dec_fail) state <= S_NOSLOT;
          else if (stat.need_div) state <= S_DIV;
          else state <= S_PADDR;
        end
        S_DIV:    if (stat.div_last) state <= S_PADDR;
        S_PADDR:  state <= S_PEVAL;
        S_PEVAL:  state <= S_DONE;
        S_RADDR:  state <= S_REVAL;
        S_REVAL:  state <= (stat.match || stat.ent_last) ? S_TADDR : S_RADDR;
        S_TADDR:  state <= S_TEVAL;
        S_TEVAL:  state <= S_DONE;
        S_FULL:   state <= S_DONE;
        S_NOSLOT: state <= S_DONE;
        S_DONE:   if (emit) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/bba_datapath.sv -----
// Block and allocation-table storage, scan registers and arithmetic.
module bba_datapath #(
  parameter int MAX_BLOCKS  = bba_pkg::MAX_BLOCKS_DEF,
  parameter int MAX_ENTRIES = bba_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  bba_pkg::cmd_t      cmd,
  input  bba_pkg::in_item_t  in_item,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data,
  output bba_pkg::stat_t     stat,
  output bba_pkg::out_item_t out_item
);

  localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [31:0] block_size;
  logic [MAX_BLOCKS-1:0]  bvalid, cwr, uwr;
  logic [MAX_ENTRIES-1:0] ent_valid;

  logic [47:0] cap_mem  [MAX_BLOCKS];
  logic [47:0] bump_mem [MAX_BLOCKS];
  logic [47:0] used_mem [MAX_BLOCKS];
  logic [35:0] tag_mem  [MAX_ENTRIES];
  logic [31:0] size_mem [MAX_ENTRIES];

  logic        op;
  logic [31:0] req, vtx;
  logic [3:0]  tgt;
  logic [BW-1:0] bcnt, pick, exact, fresh, sel;
  logic [EW-1:0] ecnt, slot;
  logic        have_pick, have_exact, have_fresh, opening, found;
  logic [47:0] best;
  logic [31:0] unit, rem, dq, fsize;
  logic [4:0]  dcnt;
  logic [EW-1:0] fidx;

  logic [BW-1:0] raddr;
  logic [47:0] rd_cap, rd_bump, rd_used;
  logic        rd_cw, rd_uw, rd_is0;
  logic [35:0] rd_tag;
  logic [31:0] rd_size;

  logic [47:0] cap_v, bump_v, used_v, fr, newcap, nbump, nused;
  logic [32:0] trial;
  logic [31:0] unit_d;
  logic        tgt_ok;
  bba_pkg::out_item_t res;

  assign tgt_ok = (int'(tgt) < MAX_BLOCKS);
  assign unit_d = (block_size == 32'd0) ? 32'd1 : block_size;

  always_comb begin
    case (cmd)
      bba_pkg::CMD_PADDR: raddr = sel;
      bba_pkg::CMD_TADDR: raddr = BW'(tgt);
      default:            raddr = bcnt;
    endcase
  end

  // Unwritten block entries read as their reset contents.
  assign cap_v  = rd_cw ? rd_cap : (rd_is0 ? {16'd0, bba_pkg::BLOCK_SIZE_RST} : 48'd0);
  assign bump_v = rd_cw ? rd_bump : 48'd0;
  assign used_v = rd_uw ? rd_used : 48'd0;
  assign fr     = cap_v - bump_v;
  assign trial  = {rem, dq[31]} - {1'b0, unit};
  assign newcap = (req <= unit) ? {16'd0, unit} :
                  48'(req) + 48'((rem != 32'd0) ? (unit - rem) : 32'd0);
  assign nbump  = (opening ? 48'd0 : bump_v) + 48'(req);
  assign nused  = (opening ? 48'd0 : used_v) + 48'(req);

  always_comb begin
    stat.is_remove = (op == bba_pkg::OP_REMOVE);
    stat.slot_hit  = !ent_valid[ecnt];
    stat.ent_last  = (ecnt == EW'(MAX_ENTRIES - 1));
    stat.blk_last  = (bcnt == BW'(MAX_BLOCKS - 1));
    stat.match     = ent_valid[ecnt] && (rd_tag == {tgt, vtx});
    stat.dec_fail  = !have_pick && !have_exact && !have_fresh;
    stat.need_div  = !have_pick && !have_exact;
    stat.div_last  = (dcnt == 5'd31);
  end

  always_ff @(posedge clk) begin
    rd_cap  <= cap_mem[raddr];
    rd_bump <= bump_mem[raddr];
    rd_used <= used_mem[raddr];
    rd_cw   <= cwr[raddr];
    rd_uw   <= uwr[raddr];
    rd_is0  <= (raddr == '0);
    rd_tag  <= tag_mem[ecnt];
    rd_size <= size_mem[ecnt];
    if (cmd == bba_pkg::CMD_PEVAL) begin
      cap_mem[sel]  <= opening ? newcap : cap_v;
      bump_mem[sel] <= nbump;
      used_mem[sel] <= nused;
      tag_mem[slot]  <= {4'(sel), vtx};
      size_mem[slot] <= req;
    end
    if (cmd == bba_pkg::CMD_TEVAL && found && tgt_ok)
      used_mem[BW'(tgt)] <= used_v - 48'(fsize);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= bba_pkg::BLOCK_SIZE_RST;
      bvalid     <= MAX_BLOCKS'(1);
      cwr        <= '0;
      uwr        <= '0;
      ent_valid  <= '0;
    end else begin
      if (cfg_we) block_size <= cfg_data;
      case (cmd)
        bba_pkg::CMD_LOAD: begin
          op <= in_item.opcode;
          req <= in_item.request_size;
          vtx <= in_item.vertex_id;
          tgt <= in_item.target_block;
          bcnt <= '0;
          ecnt <= '0;
          have_pick <= 1'b0;
          have_exact <= 1'b0;
          have_fresh <= 1'b0;
          found <= 1'b0;
        end
        bba_pkg::CMD_SLOT: begin
          if (!ent_valid[ecnt]) slot <= ecnt;
          else if (!stat.ent_last) ecnt <= ecnt + 1'b1;
        end
        bba_pkg::CMD_BEVAL: begin
          if (!bvalid[bcnt]) begin
            if (!have_fresh) begin
              fresh <= bcnt;
              have_fresh <= 1'b1;
            end
          end else begin
            if (fr > 48'(req) && (!have_pick || fr < best)) begin
              pick <= bcnt;
              best <= fr;
              have_pick <= 1'b1;
            end
            if (fr == 48'(req) && !have_exact) begin
              exact <= bcnt;
              have_exact <= 1'b1;
            end
          end
          if (!stat.blk_last) bcnt <= bcnt + 1'b1;
        end
        bba_pkg::CMD_DECIDE: begin
          opening <= stat.need_div;
          sel  <= have_pick ? pick : (have_exact ? exact : fresh);
          unit <= unit_d;
          rem  <= '0;
          dq   <= req;
          dcnt <= '0;
        end
        bba_pkg::CMD_DIV: begin
          rem  <= trial[32] ? {rem[30:0], dq[31]} : trial[31:0];
          dq   <= {dq[30:0], 1'b0};
          dcnt <= dcnt + 1'b1;
        end
        bba_pkg::CMD_PEVAL: begin
          bvalid[sel] <= 1'b1;
          cwr[sel] <= 1'b1;
          uwr[sel] <= 1'b1;
          ent_valid[slot] <= 1'b1;
          res.status <= bba_pkg::ST_OK;
          res.block_index <= 4'(sel);
          res.offset <= opening ? 48'd0 : bump_v;
          res.free_space <= (opening ? newcap : cap_v) - nbump;
        end
        bba_pkg::CMD_REVAL: begin
          if (stat.match) begin
            found <= 1'b1;
            fidx  <= ecnt;
            fsize <= rd_size;
          end else if (!stat.ent_last) ecnt <= ecnt + 1'b1;
        end
        bba_pkg::CMD_TEVAL: begin
          if (found) begin
            ent_valid[fidx] <= 1'b0;
            if (tgt_ok) uwr[BW'(tgt)] <= 1'b1;
          end
          res.status <= found ? bba_pkg::ST_OK : bba_pkg::ST_NOT_FOUND;
          res.block_index <= tgt;
          res.offset <= 48'd0;
          res.free_space <= tgt_ok ? fr : 48'd0;
        end
        bba_pkg::CMD_FULL, bba_pkg::CMD_NOSLOT: begin
          res.status <= (cmd == bba_pkg::CMD_FULL) ? bba_pkg::ST_FULL : bba_pkg::ST_NO_SLOT;
          res.block_index <= 4'd0;
          res.offset <= 48'd0;
          res.free_space <= 48'd0;
        end
        bba_pkg::CMD_EMIT: out_item <= res;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/block_bump_allocator_core.sv -----
// Top level of the best-fit block bump allocator.
// One item is worked at a time. An allocate scans the table valid bits for a free
// entry (one per cycle, up to MAX_ENTRIES), then every block slot through the
// registered block memory read; opening a block adds a bit-serial remainder step.
// A remove scans the table entry by entry until it finds a match or reaches the
// last entry. The result waits in an output register, and the next item is taken
// once the current one is handed to that register.
module block_bump_allocator_core #(
  parameter int MAX_BLOCKS  = bba_pkg::MAX_BLOCKS_DEF,
  parameter int MAX_ENTRIES = bba_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bba_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output bba_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data
);

  bba_pkg::stat_t stat;
  bba_pkg::cmd_t  cmd;

  bba_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  bba_datapath #(.MAX_BLOCKS(MAX_BLOCKS), .MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_item(in_item), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .stat(stat), .out_item(out_item)
  );

endmodule

// ----- rtl/bba_checker.sv -----
// Port-level checks for the bump allocator, bound to the top level.
`include "block_bump_allocator_core_macros.svh"

module bba_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input bba_pkg::out_item_t out_item
);

  `BBA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "result dropped or changed while stalled")
  `BBA_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second item taken while one is in work")
  `BBA_ASSERT_IMP(a_fail_zero, out_valid && (out_item.status == bba_pkg::ST_FULL || out_item.status == bba_pkg::ST_NO_SLOT), out_item.block_index == 4'd0 && out_item.offset == 48'd0 && out_item.free_space == 48'd0, "failed allocate with nonzero fields")
  `BBA_ASSERT_IMP(a_nf_offset, out_valid && out_item.status == bba_pkg::ST_NOT_FOUND, out_item.offset == 48'd0, "remove result with nonzero offset")

endmodule

bind block_bump_allocator_core bba_checker u_bba_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
);

// ----- bench/block_bump_allocator_core_test.sv -----
// Self-checking testbench for the best-fit block bump allocator core.
module block_bump_allocator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = 16;
  localparam int NENT = 256;
  localparam int LIMIT = 3000000;

  logic clk, rst, in_valid, in_ready, out_valid, out_ready, cfg_we;
  bba_pkg::in_item_t in_item;
  bba_pkg::out_item_t out_item;
  logic [31:0] cfg_data;

  block_bump_allocator_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // allocator image
  logic [31:0] unit_size;
  bit          blk_live [NBLK];
  logic [47:0] blk_cap  [NBLK];
  logic [47:0] blk_bump [NBLK];
  logic [47:0] blk_used [NBLK];
  bit          ent_live [NENT];
  logic [3:0]  ent_blk  [NENT];
  logic [31:0] ent_vtx  [NENT];
  logic [31:0] ent_size [NENT];

  bba_pkg::out_item_t pending_results[$];
  bit idle_on;
  int mismatches, results_seen, items_sent, full_hits, noslot_hits, cycles;

  typedef struct {
    bba_pkg::in_item_t  item;
    bit                 typed;
    bba_pkg::out_item_t want;
  } dir_row_t;
  dir_row_t dir_rows[$];

  function automatic bba_pkg::in_item_t mk(logic op, logic [31:0] req, logic [31:0] vtx,
                                           logic [3:0] tgt);
    bba_pkg::in_item_t it;
    it.opcode = op;
    it.request_size = req;
    it.vertex_id = vtx;
    it.target_block = tgt;
    return it;
  endfunction

  function automatic bba_pkg::out_item_t mk_res(bba_pkg::status_t st, logic [3:0] b,
                                                logic [47:0] off, logic [47:0] fr);
    bba_pkg::out_item_t r;
    r.status = st;
    r.block_index = b;
    r.offset = off;
    r.free_space = fr;
    return r;
  endfunction

  function automatic int live_entries();
    int n;
    n = 0;
    for (int i = 0; i < NENT; i++) n += ent_live[i];
    return n;
  endfunction

  function automatic void reset_image();
    unit_size = bba_pkg::BLOCK_SIZE_RST;
    for (int i = 0; i < NBLK; i++) begin
      blk_live[i] = 0;
      blk_cap[i] = '0;
      blk_bump[i] = '0;
      blk_used[i] = '0;
    end
    blk_live[0] = 1;
    blk_cap[0] = {16'd0, bba_pkg::BLOCK_SIZE_RST};
    for (int i = 0; i < NENT; i++) ent_live[i] = 0;
  endfunction

  // best-fit placement / release, updates the image
  function automatic bba_pkg::out_item_t place_or_release(bba_pkg::in_item_t it);
    int slot, pick, exact, fresh;
    logic [47:0] best, fr, req, off;
    longint unsigned unit, nunits, req64;
    slot = -1; pick = -1; exact = -1; fresh = -1;
    best = '0;
    req = {16'd0, it.request_size};
    if (it.opcode == bba_pkg::OP_ALLOC) begin
      for (int i = 0; i < NENT; i++)
        if (!ent_live[i] && slot < 0) slot = i;
      if (slot < 0) return mk_res(bba_pkg::ST_FULL, 0, 0, 0);
      for (int i = 0; i < NBLK; i++) begin
        if (!blk_live[i]) begin
          if (fresh < 0) fresh = i;
        end else begin
          fr = blk_cap[i] - blk_bump[i];
          if (fr > req && (pick < 0 || fr < best)) begin
            pick = i;
            best = fr;
          end
          if (fr == req && exact < 0) exact = i;
        end
      end
      if (pick < 0) pick = exact;
      if (pick < 0) begin
        if (fresh < 0) return mk_res(bba_pkg::ST_NO_SLOT, 0, 0, 0);
        pick = fresh;
        unit = (unit_size == 0) ? 64'd1 : {32'd0, unit_size};
        req64 = {32'd0, it.request_size};
        if (req64 <= unit) nunits = 1;
        else nunits = (req64 + unit - 1) / unit;
        blk_live[pick] = 1;
        blk_cap[pick] = 48'(nunits * unit);
        blk_bump[pick] = '0;
        blk_used[pick] = '0;
      end
      off = blk_bump[pick];
      blk_bump[pick] = off + req;
      blk_used[pick] = blk_used[pick] + req;
      ent_live[slot] = 1;
      ent_blk[slot] = 4'(pick);
      ent_vtx[slot] = it.vertex_id;
      ent_size[slot] = it.request_size;
      return mk_res(bba_pkg::ST_OK, 4'(pick), off, blk_cap[pick] - blk_bump[pick]);
    end else begin
      bba_pkg::status_t st;
      st = bba_pkg::ST_NOT_FOUND;
      for (int i = 0; i < NENT; i++) begin
        if (st == bba_pkg::ST_NOT_FOUND && ent_live[i] && ent_blk[i] == it.target_block &&
            ent_vtx[i] == it.vertex_id) begin
          blk_used[it.target_block] = blk_used[it.target_block] - {16'd0, ent_size[i]};
          ent_live[i] = 0;
          st = bba_pkg::ST_OK;
        end
      end
      return mk_res(st, it.target_block, 0,
                    blk_cap[it.target_block] - blk_bump[it.target_block]);
    end
  endfunction

  task automatic send(bba_pkg::in_item_t it, bit typed, bba_pkg::out_item_t want);
    bba_pkg::out_item_t got;
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    got = place_or_release(it);
    if (got.status == bba_pkg::ST_FULL) full_hits++;
    if (got.status == bba_pkg::ST_NO_SLOT) noslot_hits++;
    pending_results.push_back(typed ? want : got);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_unit(logic [31:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    unit_size = v;
  endtask

  task automatic send_random();
    bba_pkg::in_item_t it;
    int k, b;
    logic [47:0] fr;
    it = mk(bba_pkg::OP_ALLOC, 0, 0, 0);
    it.vertex_id = $urandom_range(0, 1) ? 32'($urandom_range(0, 7)) : $urandom;
    if ($urandom_range(0, 99) < 35) begin
      it.opcode = bba_pkg::OP_REMOVE;
      it.target_block = 4'($urandom_range(0, 15));
      if (live_entries() != 0 && $urandom_range(0, 4) != 0) begin
        do k = $urandom_range(0, NENT - 1); while (!ent_live[k]);
        it.target_block = ent_blk[k];
        it.vertex_id = ent_vtx[k];
      end
    end else begin
      case ($urandom_range(0, 4))
        0: it.request_size = $urandom_range(0, 16);
        1: it.request_size = $urandom_range(0, 4096);
        2: it.request_size = $urandom;
        default: begin
          b = $urandom_range(0, NBLK - 1);
          fr = blk_cap[b] - blk_bump[b];
          it.request_size = (fr[47:32] == 0) ? fr[31:0] : $urandom_range(0, 100000);
        end
      endcase
    end
    send(it, 0, '0);
  endtask

  // result side
  initial begin
    int stall;
    bba_pkg::out_item_t want;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_item);
        end else begin
          want = pending_results.pop_front();
          if (out_item.status !== want.status || out_item.block_index !== want.block_index ||
              out_item.offset !== want.offset || out_item.free_space !== want.free_space) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p got %p", want, out_item);
          end
        end
      end
      if (stall > 0) stall--;
      else if (idle_on && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 12);
      out_ready <= !rst && stall == 0;
    end
  end

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    idle_on = 1;
    reset_image();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    dir_rows.push_back('{mk(bba_pkg::OP_ALLOC, 0, 0, 0), 1,
                         mk_res(bba_pkg::ST_OK, 0, 0, 48'd4194304)});
    dir_rows.push_back('{mk(bba_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF), 0, '0});
    dir_rows.push_back('{mk(bba_pkg::OP_ALLOC, 32'd4194304, 5, 0), 0, '0});
    dir_rows.push_back('{mk(bba_pkg::OP_ALLOC, 1, 6, 0), 0, '0});
    dir_rows.push_back('{mk(bba_pkg::OP_REMOVE, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(bba_pkg::OP_REMOVE, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(bba_pkg::OP_REMOVE, 0, 32'hFFFF_FFFF, 4'hF), 1,
                         mk_res(bba_pkg::ST_NOT_FOUND, 4'hF, 0, 0)});
    dir_rows.push_back('{mk(bba_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1), 0, '0});
    dir_rows.push_back('{mk(bba_pkg::OP_ALLOC, 12345, 32'hAAAA_AAAA, 0), 0, '0});
    dir_rows.push_back('{mk(bba_pkg::OP_REMOVE, 0, 32'h5555_5555, 2), 0, '0});
    dir_rows.push_back('{mk(bba_pkg::OP_ALLOC, 32'h8000_0000, 32'h5555_5555, 4'hA), 0, '0});
    dir_rows.push_back('{mk(bba_pkg::OP_REMOVE, 0, 32'hAAAA_AAAA, 2), 0, '0});
    foreach (dir_rows[i]) send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    write_unit(32'd0);
    repeat (20) send_random();
    settle();
    repeat (20) send_random();

    write_unit(32'hFFFF_FFFF);
    repeat (30) send_random();

    // fill the allocation table, overflow it, then release part of it
    write_unit(32'd64);
    while (live_entries() < NENT)
      send(mk(bba_pkg::OP_ALLOC, 0, $urandom, 4'($urandom)), 0, '0);
    repeat (3) send(mk(bba_pkg::OP_ALLOC, $urandom, $urandom, 0), 0, '0);
    settle();
    repeat (30) begin
      int k;
      do k = $urandom_range(0, NENT - 1); while (!ent_live[k]);
      send(mk(bba_pkg::OP_REMOVE, $urandom, ent_vtx[k], ent_blk[k]), 0, '0);
    end

    write_unit(32'd1);
    repeat (50) send_random();
    idle_on = 0;
    repeat (30) send_random();
    settle();
    repeat (50) @(posedge clk);

    $display("%0d items, %0d results; %0d table-full and %0d no-slot responses",
             items_sent, results_seen, full_hits, noslot_hits);
    $display("block sizes covered: reset default, 0, 1, 64, 0xFFFFFFFF");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/bba_pkg.sv
rtl/bba_ctrl.sv
rtl/bba_datapath.sv
rtl/block_bump_allocator_core.sv
rtl/bba_checker.sv
bench/block_bump_allocator_core_test.sv
